// ----- rtl/assert_macros.svh -----
// assertion macros shared by the pps edge classifier rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define PEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define PEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pec_pkg.sv -----
// types and constants for the pps edge classifier
// no dependencies
`default_nettype none

package pec_pkg;

    localparam int EDGE_TIME_BITS = 40;
    localparam int OUT_TIME_BITS  = 40;
    localparam int FIX_BITS       = 8;
    localparam int REPEAT_BITS    = 4;
    localparam int CLASS_BITS     = 4;
    localparam int LIMIT_BITS     = 21;

    localparam logic [FIX_BITS-1:0]    MIN_FIX_RESET = 8'd4;
    localparam logic [REPEAT_BITS-1:0] REPEAT_LIMIT  = 4'd10;

    localparam logic [LIMIT_BITS-1:0] LIM_DUR_5HZ    = 21'd100000;
    localparam logic [LIMIT_BITS-1:0] LIM_5HZ_LO     = 21'd199000;
    localparam logic [LIMIT_BITS-1:0] LIM_5HZ_HI     = 21'd201000;
    localparam logic [LIMIT_BITS-1:0] LIM_HALF_LO    = 21'd499000;
    localparam logic [LIMIT_BITS-1:0] LIM_HALF_HI    = 21'd501000;
    localparam logic [LIMIT_BITS-1:0] LIM_SEC_LO     = 21'd999000;
    localparam logic [LIMIT_BITS-1:0] LIM_SEC_HI     = 21'd1001000;
    localparam logic [LIMIT_BITS-1:0] LIM_TWO_SEC_LO = 21'd1999000;
    localparam logic [LIMIT_BITS-1:0] LIM_TWO_SEC_HI = 21'd2001000;

    typedef enum logic [CLASS_BITS-1:0] {
        PC_NO_FIX       = 4'd0,
        PC_TOO_SHORT    = 4'd1,
        PC_5HZ_OK       = 4'd2,
        PC_5HZ_BAD_DUR  = 4'd3,
        PC_5HZ_TO_1HZ   = 4'd4,
        PC_INVISIBLE_OK = 4'd5,
        PC_1HZ_TRAILING = 4'd6,
        PC_1HZ_SQ_OK    = 4'd7,
        PC_1HZ_SQ_IGN   = 4'd8,
        PC_1HZ_LEAD_OK  = 4'd9,
        PC_1HZ_TO_2HZ   = 4'd10,
        PC_HALF_SHORT   = 4'd11,
        PC_HALF_OK      = 4'd12,
        PC_HALF_LONG    = 4'd13,
        PC_TOO_LONG     = 4'd14
    } pulse_class_t;

endpackage

`default_nettype wire

// ----- rtl/pec_ifs.sv -----
// edge event and result channel interfaces for the pps edge classifier
// depends on pec_pkg
`default_nettype none

interface pec_edge_if import pec_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [EDGE_TIME_BITS-1:0] edge_time_us;
    logic                      line_level;
    logic [FIX_BITS-1:0]       fix_count;

    modport source (output valid, output edge_time_us, output line_level,
                    output fix_count, input ready);
    modport sink   (input valid, input edge_time_us, input line_level,
                    input fix_count, output ready);
endinterface

interface pec_result_if import pec_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     pulse_accepted;
    logic [CLASS_BITS-1:0]    pulse_class;
    logic [OUT_TIME_BITS-1:0] cycle_us;
    logic [OUT_TIME_BITS-1:0] duration_us;

    modport source (output valid, output pulse_accepted, output pulse_class,
                    output cycle_us, output duration_us, input ready);
    modport sink   (input valid, input pulse_accepted, input pulse_class,
                    input cycle_us, input duration_us, output ready);
endinterface

`default_nettype wire

// ----- rtl/pec_input_reg.sv -----
// input register stage: takes edge events off the input channel
// depends on pec_pkg and pec_edge_if
`default_nettype none

module pec_input_reg import pec_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    pec_edge_if.sink                  edges,
    input  logic                      advance,
    output logic                      stage_valid,
    output logic [EDGE_TIME_BITS-1:0] stage_time,
    output logic                      stage_level,
    output logic [FIX_BITS-1:0]       stage_fix
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [EDGE_TIME_BITS-1:0] time_reg;
    logic                      level_reg;
    logic [FIX_BITS-1:0]       fix_reg;
    logic                      take;

    assign edges.ready = !valid_reg || advance;
    assign take        = edges.valid && edges.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            time_reg  <= edges.edge_time_us;
            level_reg <= edges.line_level;
            fix_reg   <= edges.fix_count;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_time  = time_reg;
    assign stage_level = level_reg;
    assign stage_fix   = fix_reg;

endmodule

`default_nettype wire

// ----- rtl/pec_level_tracker.sv -----
// per-level time memory, repeat counter and cycle / duration differences
// depends on pec_pkg
`default_nettype none

module pec_level_tracker import pec_pkg::*;
#(
    parameter int TIME_BITS = 40
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      update,
    input  logic [EDGE_TIME_BITS-1:0] edge_time,
    input  logic                      level,
    output logic [TIME_BITS-1:0]      cycle,
    output logic [TIME_BITS-1:0]      duration,
    output logic                      emit
);

    logic [TIME_BITS-1:0]   seen_time_reg [2];
    logic                   prev_level_reg;
    logic                   prev_known_reg;
    logic [REPEAT_BITS-1:0] repeat_count_reg;
    logic [REPEAT_BITS-1:0] repeat_count_next;
    logic [TIME_BITS-1:0]   now;
    logic [TIME_BITS-1:0]   dur_raw;
    logic                   is_repeat;
    logic                   invisible;
    logic [REPEAT_BITS-1:0] repeat_inc;

    assign now     = TIME_BITS'(edge_time);
    assign cycle   = now - seen_time_reg[level];
    assign dur_raw = now - seen_time_reg[~level];

    assign is_repeat = prev_known_reg && (level == prev_level_reg);
    assign invisible = (cycle > TIME_BITS'(LIM_SEC_LO)) && (cycle < TIME_BITS'(LIM_SEC_HI));
    assign emit      = !is_repeat || invisible;
    assign duration  = (is_repeat && invisible) ? '0 : dur_raw;
    assign repeat_inc = repeat_count_reg + 1'b1;

    always_comb
    begin
        repeat_count_next = '0;
        if (is_repeat && !invisible)
        begin
            repeat_count_next = (repeat_inc == REPEAT_LIMIT) ? REPEAT_BITS'(1) : repeat_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_time_reg[0] <= '0;
            seen_time_reg[1] <= '0;
            prev_level_reg   <= 1'b0;
            prev_known_reg   <= 1'b0;
            repeat_count_reg <= '0;
        end
        else if (update)
        begin
            seen_time_reg[level] <= now;
            prev_level_reg       <= level;
            prev_known_reg       <= 1'b1;
            repeat_count_reg     <= repeat_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pec_classifier.sv -----
// cycle and duration windows to pulse class and accept flag
// depends on pec_pkg
`default_nettype none

module pec_classifier import pec_pkg::*;
#(
    parameter int TIME_BITS = 40
)
(
    input  logic                 level,
    input  logic [TIME_BITS-1:0] cycle,
    input  logic [TIME_BITS-1:0] duration,
    input  logic [FIX_BITS-1:0]  fix_count,
    input  logic [FIX_BITS-1:0]  min_fix_count,
    output logic                 accepted,
    output pulse_class_t         pulse_class
);

    always_comb
    begin
        accepted    = 1'b0;
        pulse_class = PC_NO_FIX;
        if (fix_count >= min_fix_count)
        begin
            if (cycle < TIME_BITS'(LIM_5HZ_LO))
            begin
                pulse_class = PC_TOO_SHORT;
            end
            else if (cycle < TIME_BITS'(LIM_5HZ_HI))
            begin
                if (duration < TIME_BITS'(LIM_DUR_5HZ))
                begin
                    accepted    = 1'b1;
                    pulse_class = PC_5HZ_OK;
                end
                else
                begin
                    pulse_class = PC_5HZ_BAD_DUR;
                end
            end
            else if (cycle < TIME_BITS'(LIM_SEC_LO))
            begin
                pulse_class = PC_5HZ_TO_1HZ;
            end
            else if (cycle < TIME_BITS'(LIM_SEC_HI))
            begin
                if (duration == '0)
                begin
                    accepted    = 1'b1;
                    pulse_class = PC_INVISIBLE_OK;
                end
                else if (duration < TIME_BITS'(LIM_HALF_LO))
                begin
                    pulse_class = PC_1HZ_TRAILING;
                end
                else if (duration < TIME_BITS'(LIM_HALF_HI))
                begin
                    accepted    = level;
                    pulse_class = level ? PC_1HZ_SQ_OK : PC_1HZ_SQ_IGN;
                end
                else
                begin
                    accepted    = 1'b1;
                    pulse_class = PC_1HZ_LEAD_OK;
                end
            end
            else if (cycle < TIME_BITS'(LIM_TWO_SEC_LO))
            begin
                pulse_class = PC_1HZ_TO_2HZ;
            end
            else if (cycle < TIME_BITS'(LIM_TWO_SEC_HI))
            begin
                if (duration < TIME_BITS'(LIM_SEC_LO))
                begin
                    pulse_class = PC_HALF_SHORT;
                end
                else if (duration < TIME_BITS'(LIM_SEC_HI))
                begin
                    accepted    = 1'b1;
                    pulse_class = PC_HALF_OK;
                end
                else
                begin
                    pulse_class = PC_HALF_LONG;
                end
            end
            else
            begin
                pulse_class = PC_TOO_LONG;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pps_edge_classifier.sv -----
// top level of the pps edge classifier: input stage, level tracker, classifier, result register
// depends on pec_pkg, pec_ifs, pec_input_reg, pec_level_tracker, pec_classifier, assert_macros.svh
// Takes one pps line change per transfer and gives at most one result per event. The event waits
// in the input register until the result register is free or being read; then it moves on to
// the result register. One event can be taken every clock cycle while the result channel does
// not stall: the per-level time registers, the last level and the repeat counter are read and
// updated as the event moves from the input register to the result register. A stalled result
// is held in the result register while the next event waits in the input register. Events whose
// level repeats, and that do not sit about one second after the last event at that level, give
// no result. min_fix_count is written through cfg_wr_en / cfg_wr_data and resets to 4.
`default_nettype none

`include "assert_macros.svh"

module pps_edge_classifier import pec_pkg::*;
#(
    parameter int TIME_BITS = 40
)
(
    input  logic                clk,
    input  logic                rst_n,
    pec_edge_if.sink            edges,
    pec_result_if.source        results,
    input  logic                cfg_wr_en,
    input  logic [FIX_BITS-1:0] cfg_wr_data
);

    logic                      advance;
    logic                      stage_valid;
    logic [EDGE_TIME_BITS-1:0] stage_time;
    logic                      stage_level;
    logic [FIX_BITS-1:0]       stage_fix;
    logic [TIME_BITS-1:0]      cycle;
    logic [TIME_BITS-1:0]      duration;
    logic                      emit;
    logic                      accepted;
    pulse_class_t              pulse_class;

    logic [FIX_BITS-1:0]       min_fix_reg;
    logic                      res_valid_reg;
    logic                      res_valid_next;
    logic                      res_accepted_reg;
    logic [CLASS_BITS-1:0]     res_class_reg;
    logic [OUT_TIME_BITS-1:0]  res_cycle_reg;
    logic [OUT_TIME_BITS-1:0]  res_duration_reg;

    assign advance = stage_valid && (!res_valid_reg || results.ready);

    pec_input_reg u_input_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .edges       (edges),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_time  (stage_time),
        .stage_level (stage_level),
        .stage_fix   (stage_fix)
    );

    pec_level_tracker #(
        .TIME_BITS (TIME_BITS)
    ) u_level_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (advance),
        .edge_time (stage_time),
        .level     (stage_level),
        .cycle     (cycle),
        .duration  (duration),
        .emit      (emit)
    );

    pec_classifier #(
        .TIME_BITS (TIME_BITS)
    ) u_classifier (
        .level         (stage_level),
        .cycle         (cycle),
        .duration      (duration),
        .fix_count     (stage_fix),
        .min_fix_count (min_fix_reg),
        .accepted      (accepted),
        .pulse_class   (pulse_class)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = emit;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            min_fix_reg   <= MIN_FIX_RESET;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
            begin
                min_fix_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_accepted_reg <= accepted;
            res_class_reg    <= pulse_class;
            res_cycle_reg    <= OUT_TIME_BITS'(cycle);
            res_duration_reg <= OUT_TIME_BITS'(duration);
        end
    end

    assign results.valid          = res_valid_reg;
    assign results.pulse_accepted = res_accepted_reg;
    assign results.pulse_class    = res_class_reg;
    assign results.cycle_us       = res_cycle_reg;
    assign results.duration_us    = res_duration_reg;

    `PEC_ASSERT_IMPLY(a_accept_class, clk, rst_n,
        res_valid_reg && res_accepted_reg,
        res_class_reg == PC_5HZ_OK || res_class_reg == PC_INVISIBLE_OK ||
        res_class_reg == PC_1HZ_SQ_OK || res_class_reg == PC_1HZ_LEAD_OK ||
        res_class_reg == PC_HALF_OK,
        "accepted pulse with a rejecting class")

    `PEC_ASSERT_IMPLY(a_invisible_dur, clk, rst_n,
        res_valid_reg && res_class_reg == PC_INVISIBLE_OK,
        res_duration_reg == '0,
        "invisible pulse with nonzero duration")

    `PEC_ASSERT_NEXT(a_stage_filled, clk, rst_n,
        edges.valid && edges.ready,
        stage_valid,
        "accepted edge event lost before the input stage")

    `PEC_ASSERT_NEXT(a_result_held, clk, rst_n,
        res_valid_reg && !results.ready,
        res_valid_reg && !advance || res_valid_reg,
        "stalled result dropped")

endmodule

`default_nettype wire
